### rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared widths, codes and payload types of the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int CMD_W      = 2;
  localparam int DATA_W     = 8;
  localparam int BITS_W     = 8;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int PKT_W      = 4;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_LEN_DEFAULT = 64;

  localparam logic [DATA_W-1:0] FLAG_BYTE     = 8'h7E;
  localparam logic [DATA_W-1:0] ESC_BYTE      = 8'h7D;
  localparam logic [DATA_W-1:0] ESC_FLAG_CODE = 8'h01;
  localparam logic [DATA_W-1:0] ESC_ESC_CODE  = 8'h02;

  localparam logic [PKT_W-1:0]  PKT_COUNT_MAX      = 4'hF;
  localparam logic [PKT_W-1:0]  PACKETS_NEEDED_RST = 4'd1;
  localparam logic [TICK_W-1:0] TICK_LIMIT_RST     = 32'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_BAD_ESCAPE = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKETS_NEEDED = 1'd0,
    REG_TICK_LIMIT     = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] rx_value;
    logic [BITS_W-1:0] rx_bits;
  } item_t;

  typedef struct packed {
    logic               data_valid;
    logic [DATA_W-1:0]  data_value;
    logic [INDEX_W-1:0] data_index;
    logic [BITS_W-1:0]  data_bits;
    logic               finished;
    status_t            status;
  } result_t;

endpackage

### rtl/efr_in_if.sv
// ----------------------------------------------------------------------------
// efr_in_if
// Input channel: commands, received bytes and ticks with valid/ready.
// ----------------------------------------------------------------------------
interface efr_in_if;
  logic                      valid;
  logic                      ready;
  logic [efr_pkg::CMD_W-1:0]  cmd;
  logic [efr_pkg::DATA_W-1:0] rx_value;
  logic [efr_pkg::BITS_W-1:0] rx_bits;

  modport source (output valid, cmd, rx_value, rx_bits, input ready);
  modport sink   (input valid, cmd, rx_value, rx_bits, output ready);
  modport mon    (input valid, ready, cmd, rx_value, rx_bits);
endinterface

### rtl/efr_out_if.sv
// ----------------------------------------------------------------------------
// efr_out_if
// Result channel: decoded bytes and exchange outcome with valid/ready.
// ----------------------------------------------------------------------------
interface efr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         data_valid;
  logic [efr_pkg::DATA_W-1:0]   data_value;
  logic [efr_pkg::INDEX_W-1:0]  data_index;
  logic [efr_pkg::BITS_W-1:0]   data_bits;
  logic                         finished;
  logic [efr_pkg::STATUS_W-1:0] status;

  modport source (output valid, data_valid, data_value, data_index, data_bits, finished,
                  status, input ready);
  modport sink   (input valid, data_valid, data_value, data_index, data_bits, finished,
                  status, output ready);
  modport mon    (input valid, ready, data_valid, data_value, data_index, data_bits,
                  finished, status);
endinterface

### rtl/efr_in_stage.sv
// ----------------------------------------------------------------------------
// efr_in_stage
// Input register that holds one accepted item for the decoder.
// ----------------------------------------------------------------------------
module efr_in_stage (
  input  logic            clk,
  input  logic            rst,
  efr_in_if.sink          din,
  input  logic            take,
  output logic            item_valid,
  output efr_pkg::item_t  item
);

  assign din.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (din.ready) begin
      item_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      item.cmd      <= din.cmd;
      item.rx_value <= din.rx_value;
      item.rx_bits  <= din.rx_bits;
    end
  end

endmodule

### rtl/efr_decoder.sv
// ----------------------------------------------------------------------------
// efr_decoder
// Configuration registers, exchange state and the per-item unstuffing logic.
// ----------------------------------------------------------------------------
module efr_decoder #(
  parameter int MAX_LEN = efr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  input  efr_pkg::item_t                 item,
  input  logic                           res_ready,
  output logic                           res_valid,
  output efr_pkg::result_t               res
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LEN);

  logic [efr_pkg::PKT_W-1:0]  packets_needed;
  logic [efr_pkg::TICK_W-1:0] tick_limit;

  logic                       active, active_next;
  logic                       esc_armed, esc_armed_next;
  logic [efr_pkg::BITS_W-1:0] held_escape_bits, held_escape_bits_next;
  logic [efr_pkg::PKT_W-1:0]  packet_count, packet_count_next;
  logic [CW-1:0]              byte_count, byte_count_next;
  logic [efr_pkg::TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;

  logic                       fire;
  logic                       esc_code_ok;
  logic [efr_pkg::DATA_W-1:0] decoded;
  logic                       ends_packet;
  logic [efr_pkg::BITS_W-1:0] merged_bits;
  logic [CW-1:0]              byte_inc;
  logic [efr_pkg::PKT_W-1:0]  packet_inc;
  logic [efr_pkg::TICK_W-1:0] tick_inc;
  logic                       done;
  logic [CW+efr_pkg::INDEX_W-1:0] index_ext;

  assign fire = item_valid && res_ready;

  assign esc_code_ok = (item.rx_value == efr_pkg::ESC_FLAG_CODE) ||
                       (item.rx_value == efr_pkg::ESC_ESC_CODE);
  assign decoded = !esc_armed ? item.rx_value :
                   (item.rx_value == efr_pkg::ESC_FLAG_CODE) ? efr_pkg::FLAG_BYTE :
                   efr_pkg::ESC_BYTE;
  assign ends_packet = !esc_armed && (item.rx_value == efr_pkg::FLAG_BYTE);
  assign merged_bits = (held_escape_bits > item.rx_bits) ? held_escape_bits : item.rx_bits;
  assign byte_inc    = byte_count + CW'(1);
  assign packet_inc  = (packet_count == efr_pkg::PKT_COUNT_MAX) ? packet_count
                                                                : packet_count + 4'd1;
  assign tick_inc    = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 32'd1;
  assign done        = ends_packet && (packets_needed != '0) && (packet_inc == packets_needed);
  assign index_ext   = {{efr_pkg::INDEX_W{1'b0}}, byte_count};

  always_comb begin
    active_next           = active;
    esc_armed_next        = esc_armed;
    held_escape_bits_next = held_escape_bits;
    packet_count_next     = packet_count;
    byte_count_next       = byte_count;
    elapsed_ticks_next    = elapsed_ticks;
    res_valid             = 1'b0;
    res                   = '0;
    if (fire) begin
      case (item.cmd)
        efr_pkg::CMD_START: begin
          active_next           = 1'b1;
          esc_armed_next        = 1'b0;
          held_escape_bits_next = '0;
          packet_count_next     = '0;
          byte_count_next       = '0;
          elapsed_ticks_next    = '0;
        end
        efr_pkg::CMD_TICK: begin
          if (active) begin
            elapsed_ticks_next = tick_inc;
            if (tick_inc >= tick_limit) begin
              active_next    = 1'b0;
              esc_armed_next = 1'b0;
              res_valid      = 1'b1;
              res.finished   = 1'b1;
              res.status     = efr_pkg::ST_TIMEOUT;
            end
          end
        end
        efr_pkg::CMD_BYTE: begin
          if (active) begin
            if (elapsed_ticks >= tick_limit) begin
              active_next    = 1'b0;
              esc_armed_next = 1'b0;
              res_valid      = 1'b1;
              res.finished   = 1'b1;
              res.status     = efr_pkg::ST_TIMEOUT;
            end else if (esc_armed && !esc_code_ok) begin
              active_next    = 1'b0;
              esc_armed_next = 1'b0;
              res_valid      = 1'b1;
              res.finished   = 1'b1;
              res.status     = efr_pkg::ST_BAD_ESCAPE;
            end else if (!esc_armed && (item.rx_value == efr_pkg::ESC_BYTE)) begin
              esc_armed_next        = 1'b1;
              held_escape_bits_next = item.rx_bits;
            end else begin
              esc_armed_next        = 1'b0;
              held_escape_bits_next = '0;
              byte_count_next       = byte_inc;
              if (ends_packet) begin
                packet_count_next = packet_inc;
              end
              res_valid      = 1'b1;
              res.data_valid = 1'b1;
              res.data_value = decoded;
              res.data_index = index_ext[efr_pkg::INDEX_W-1:0];
              res.data_bits  = merged_bits;
              if (done) begin
                active_next  = 1'b0;
                res.finished = 1'b1;
                res.status   = efr_pkg::ST_OK;
              end else if (byte_inc >= FULL_COUNT) begin
                active_next  = 1'b0;
                res.finished = 1'b1;
                res.status   = efr_pkg::ST_FULL;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packets_needed <= efr_pkg::PACKETS_NEEDED_RST;
      tick_limit     <= efr_pkg::TICK_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efr_pkg::REG_PACKETS_NEEDED: packets_needed <= cfg_data[efr_pkg::PKT_W-1:0];
        efr_pkg::REG_TICK_LIMIT:     tick_limit     <= cfg_data[efr_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      esc_armed        <= 1'b0;
      held_escape_bits <= '0;
      packet_count     <= '0;
      byte_count       <= '0;
      elapsed_ticks    <= '0;
    end else begin
      active           <= active_next;
      esc_armed        <= esc_armed_next;
      held_escape_bits <= held_escape_bits_next;
      packet_count     <= packet_count_next;
      byte_count       <= byte_count_next;
      elapsed_ticks    <= elapsed_ticks_next;
    end
  end

endmodule

### rtl/efr_out_stage.sv
// ----------------------------------------------------------------------------
// efr_out_stage
// Result register that presents one result item on the output channel.
// ----------------------------------------------------------------------------
module efr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  efr_pkg::result_t  res,
  output logic              res_ready,
  efr_out_if.source         dout
);

  assign res_ready = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (res_ready) begin
      dout.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      dout.data_valid <= res.data_valid;
      dout.data_value <= res.data_value;
      dout.data_index <= res.data_index;
      dout.data_bits  <= res.data_bits;
      dout.finished   <= res.finished;
      dout.status     <= res.status;
    end
  end

endmodule

### rtl/escaped_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core
// Byte-stuffed response deframer for the 7E/7D escape scheme.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled:
// an item is registered, decoded combinationally against the exchange state,
// and its result, if any, is loaded into the output register once that
// register is free or being read. Ready drops only when the output register
// holds an untaken result and the input register is also full. Starts,
// escape bytes, ticks that do not time out, unused commands and items
// outside an exchange give no result. Configuration writes take effect on
// the next cycle.
module escaped_frame_receiver_core #(
  parameter int MAX_LEN = efr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efr_pkg::CFG_DATA_W-1:0] cfg_data,
  efr_in_if.sink                         din,
  efr_out_if.source                      dout
);

  logic             item_valid;
  efr_pkg::item_t   item;
  logic             res_ready;
  logic             res_valid;
  efr_pkg::result_t res;

  efr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .take       (res_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  efr_decoder #(
    .MAX_LEN (MAX_LEN)
  ) u_dec (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  efr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .dout      (dout)
  );

endmodule

### rtl/efr_checker.sv
// ----------------------------------------------------------------------------
// efr_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module efr_checker (
  input logic       clk,
  input logic       rst,
  efr_out_if.source dout
);

  a_status_needs_finish : assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.finished |-> dout.status == efr_pkg::ST_OK)
    else $error("Status is set on a result that does not finish the exchange.");

  a_empty_data_zero : assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.data_valid |->
      dout.data_value == '0 && dout.data_index == '0 && dout.data_bits == '0)
    else $error("Data fields are not zero on a result without data.");

  a_error_no_data : assert property (@(posedge clk) disable iff (rst)
    dout.valid && (dout.status == efr_pkg::ST_TIMEOUT ||
                   dout.status == efr_pkg::ST_BAD_ESCAPE) |-> !dout.data_valid)
    else $error("A timeout or invalid escape result carries data.");

  a_empty_result_finishes : assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.data_valid |-> dout.finished)
    else $error("A result carries neither data nor an outcome.");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |=> dout.valid && $stable(dout.data_value) &&
      $stable(dout.data_index) && $stable(dout.finished) && $stable(dout.status))
    else $error("A stalled result changed before its transfer.");

endmodule

bind escaped_frame_receiver_core efr_checker u_efr_checker (
  .clk  (clk),
  .rst  (rst),
  .dout (dout)
);

### verif/escaped_frame_receiver_core_test.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core_test
// Self-checking bench for the byte-stuffed response deframer. A scoreboard
// tracks the exchange state for every accepted transfer, predicts the decoded
// byte or outcome, and checks each result transfer in order. A short directed
// run covers the escape rules and the edge cases. Random exchanges then run
// under several register settings, with idle gaps on both channels and one
// long receiver stall.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_core_test;
  import efr_pkg::*;

  localparam int BUFFER_LEN = MAX_LEN_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 30;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class deframe_tracker;
    logic [PKT_W-1:0]  need_packets;
    logic [TICK_W-1:0] tick_limit;
    bit                in_exchange;
    bit                escape_armed;
    logic [BITS_W-1:0] escape_tag;
    logic [PKT_W-1:0]  packets_seen;
    int unsigned       bytes_stored;
    logic [TICK_W-1:0] ticks_seen;
    result_t           pending_results[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       outcomes[4];

    function new();
      need_packets = PACKETS_NEEDED_RST;
      tick_limit = TICK_LIMIT_RST;
      in_exchange = 0;
      escape_armed = 0;
      escape_tag = '0;
      packets_seen = '0;
      bytes_stored = 0;
      ticks_seen = '0;
      mismatches = 0;
      results_seen = 0;
      foreach (outcomes[i]) outcomes[i] = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PACKETS_NEEDED) need_packets = val[PKT_W-1:0];
      else tick_limit = val;
    endfunction

    function void end_exchange(status_t st);
      result_t r;
      r = '0;
      r.finished = 1'b1;
      r.status = st;
      in_exchange = 0;
      escape_armed = 0;
      pending_results.push_back(r);
    endfunction

    // Returns 1 when the transfer is acted on, 0 when the block ignores it.
    function bit take_item(item_t it);
      result_t           r;
      logic [DATA_W-1:0] decoded;
      bit                ends_packet;
      bit                completes;
      if (it.cmd == CMD_START) begin
        in_exchange = 1;
        escape_armed = 0;
        escape_tag = '0;
        packets_seen = '0;
        bytes_stored = 0;
        ticks_seen = '0;
        return 1;
      end
      if (!in_exchange || (it.cmd != CMD_BYTE && it.cmd != CMD_TICK)) return 0;
      if (it.cmd == CMD_TICK) begin
        if (ticks_seen != '1) ticks_seen++;
        if (ticks_seen >= tick_limit) end_exchange(ST_TIMEOUT);
        return 1;
      end
      if (ticks_seen >= tick_limit) begin
        end_exchange(ST_TIMEOUT);
        return 1;
      end
      decoded = it.rx_value;
      ends_packet = 0;
      if (escape_armed) begin
        if (it.rx_value == ESC_FLAG_CODE) decoded = FLAG_BYTE;
        else if (it.rx_value == ESC_ESC_CODE) decoded = ESC_BYTE;
        else begin
          end_exchange(ST_BAD_ESCAPE);
          return 1;
        end
        escape_armed = 0;
      end else if (it.rx_value == ESC_BYTE) begin
        escape_armed = 1;
        escape_tag = it.rx_bits;
        return 1;
      end else if (it.rx_value == FLAG_BYTE) begin
        ends_packet = 1;
      end
      r = '0;
      r.data_valid = 1'b1;
      r.data_value = decoded;
      r.data_index = bytes_stored[INDEX_W-1:0];
      r.data_bits = (escape_tag > it.rx_bits) ? escape_tag : it.rx_bits;
      r.status = ST_OK;
      escape_tag = '0;
      bytes_stored++;
      completes = 0;
      if (ends_packet) begin
        if (packets_seen != PKT_COUNT_MAX) packets_seen++;
        completes = (need_packets != '0) && (packets_seen == need_packets);
      end
      if (completes) begin
        in_exchange = 0;
        r.finished = 1'b1;
      end else if (bytes_stored >= BUFFER_LEN) begin
        in_exchange = 0;
        escape_armed = 0;
        r.finished = 1'b1;
        r.status = ST_FULL;
      end
      pending_results.push_back(r);
      return 1;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: value %h index %0d fin %0d",
                                  got.data_value, got.data_index, got.finished));
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (got.data_valid !== want.data_valid)
        report_mismatch($sformatf("data_valid %b, want %b", got.data_valid, want.data_valid));
      if (got.data_value !== want.data_value)
        report_mismatch($sformatf("data_value %h, want %h", got.data_value, want.data_value));
      if (got.data_index !== want.data_index)
        report_mismatch($sformatf("data_index %0d, want %0d", got.data_index, want.data_index));
      if (got.data_bits !== want.data_bits)
        report_mismatch($sformatf("data_bits %h, want %h", got.data_bits, want.data_bits));
      if (got.finished !== want.finished)
        report_mismatch($sformatf("finished %b, want %b", got.finished, want.finished));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (want.finished) outcomes[want.status]++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  efr_in_if  din();
  efr_out_if dout();

  deframe_tracker tracker;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    input_transfers;
  int unsigned    hold_left;
  int unsigned    cycle_count;
  bit             hold_request;

  escaped_frame_receiver_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .din      (din),
    .dout     (dout)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (!rst && dout.valid && dout.ready) begin
        got.data_valid = dout.data_valid;
        got.data_value = dout.data_value;
        got.data_index = dout.data_index;
        got.data_bits = dout.data_bits;
        got.finished = dout.finished;
        got.status = status_t'(dout.status);
        tracker.check_result(got);
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                           logic [BITS_W-1:0] bits, output bit consumed);
    item_t it;
    it.cmd = cmd;
    it.rx_value = value;
    it.rx_bits = bits;
    din.valid <= 1'b1;
    din.cmd <= cmd;
    din.rx_value <= value;
    din.rx_bits <= bits;
    do @(posedge clk); while (!din.ready);
    consumed = tracker.take_item(it);
    if (consumed) input_transfers++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      din.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_directed(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                               logic [BITS_W-1:0] bits);
    bit consumed;
    send_item(cmd, value, bits, consumed);
    sender_gap();
  endtask

  // Waits until every expected result has arrived, plus the pipeline depth for
  // transfers that give no result, then writes both registers.
  task automatic settle_and_configure(logic [PKT_W-1:0] packets, logic [TICK_W-1:0] ticks);
    din.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PACKETS_NEEDED;
    cfg_data <= CFG_DATA_W'(packets);
    @(posedge clk);
    cfg_index <= REG_TICK_LIMIT;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(REG_PACKETS_NEEDED, CFG_DATA_W'(packets));
    tracker.set_reg(REG_TICK_LIMIT, ticks);
  endtask

  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    int unsigned pick;
    int unsigned flag_pct;
    it.rx_bits = BITS_W'($urandom_range(255));
    it.rx_value = DATA_W'($urandom_range(255));
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    flag_pct = (tracker.need_packets == '0) ? 30 : 10;
    if (!tracker.in_exchange) begin
      if (roll < 80) it.cmd = CMD_START;
      else if (roll < 90) it.cmd = CMD_BYTE;
      else if (roll < 96) it.cmd = CMD_TICK;
      else it.cmd = CMD_UNUSED;
    end else if (roll < 2) begin
      it.cmd = CMD_START;
    end else if (roll < 3) begin
      it.cmd = CMD_UNUSED;
    end else if (roll < 11) begin
      it.cmd = CMD_TICK;
    end else begin
      it.cmd = CMD_BYTE;
      if (tracker.escape_armed) begin
        if (pick < 45) it.rx_value = ESC_FLAG_CODE;
        else if (pick < 90) it.rx_value = ESC_ESC_CODE;
      end else if (pick < flag_pct) begin
        it.rx_value = FLAG_BYTE;
      end else if (pick < flag_pct + 8) begin
        it.rx_value = ESC_BYTE;
      end
    end
    return it;
  endfunction

  task automatic run_phase(logic [PKT_W-1:0] packets, logic [TICK_W-1:0] ticks,
                           int unsigned count, int unsigned pressure_after);
    int unsigned done_items;
    item_t       it;
    bit          consumed;
    done_items = 0;
    settle_and_configure(packets, ticks);
    while (done_items < count) begin
      it = random_item();
      send_item(it.cmd, it.rx_value, it.rx_bits, consumed);
      if (consumed) begin
        done_items++;
        if (pressure_after != 0 && done_items == pressure_after) hold_request = 1;
      end
      sender_gap();
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    din.valid = 1'b0;
    din.cmd = '0;
    din.rx_value = '0;
    din.rx_bits = '0;
    input_transfers = 0;
    tx_idle_pct = 16;
    rx_idle_pct = 76;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    settle_and_configure(4'd2, 32'd1000);
    send_directed(CMD_BYTE, 8'h55, 8'hFF);
    send_directed(CMD_TICK, 8'h00, 8'h00);
    send_directed(CMD_UNUSED, 8'hAA, 8'h55);
    send_directed(CMD_START, 8'h00, 8'h00);
    send_directed(CMD_BYTE, 8'h00, 8'h00);
    send_directed(CMD_BYTE, 8'hFF, 8'hFF);
    send_directed(CMD_BYTE, ESC_BYTE, 8'h80);
    send_directed(CMD_BYTE, ESC_FLAG_CODE, 8'h7F);
    send_directed(CMD_BYTE, ESC_BYTE, 8'h10);
    send_directed(CMD_BYTE, ESC_ESC_CODE, 8'hA0);
    send_directed(CMD_UNUSED, 8'h7E, 8'hFF);
    send_directed(CMD_TICK, 8'hFF, 8'hFF);
    send_directed(CMD_BYTE, FLAG_BYTE, 8'h01);
    send_directed(CMD_START, 8'hFF, 8'hFF);
    send_directed(CMD_BYTE, 8'h41, 8'h5A);
    send_directed(CMD_BYTE, FLAG_BYTE, 8'h00);
    send_directed(CMD_BYTE, FLAG_BYTE, 8'hFF);
    send_directed(CMD_START, 8'h00, 8'h00);
    send_directed(CMD_BYTE, ESC_BYTE, 8'hC3);
    send_directed(CMD_BYTE, 8'h33, 8'h11);

    // Zero packets never completes; the timeout ends the exchange instead.
    settle_and_configure(4'd0, 32'd1);
    send_directed(CMD_START, 8'h00, 8'h00);
    send_directed(CMD_BYTE, FLAG_BYTE, 8'h3C);
    send_directed(CMD_TICK, 8'h00, 8'h00);

    // With a zero timeout a byte is not decoded and the exchange times out.
    settle_and_configure(4'd1, 32'd0);
    send_directed(CMD_START, 8'h00, 8'h00);
    send_directed(CMD_BYTE, 8'h5A, 8'hA5);

    run_phase(4'd1, 32'd1000, 150, 0);
    run_phase(4'd15, 32'hFFFF_FFFF, 150, 0);
    run_phase(4'd3, 32'd10, 150, 0);
    tx_idle_pct = 76;
    rx_idle_pct = 16;
    run_phase(4'd0, 32'd20, 150, 0);
    run_phase(4'd2, 32'd2, 150, 0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4'd7, 32'd500, 150, 20);
    run_phase(4'd4, 32'd1, 150, 0);

    din.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d input transfers and %0d checked results over several settings.",
             input_transfers, tracker.results_seen);
    $display("Exchange outcomes: %0d ok, %0d timeout, %0d bad escape, %0d buffer full.",
             tracker.outcomes[ST_OK], tracker.outcomes[ST_TIMEOUT],
             tracker.outcomes[ST_BAD_ESCAPE], tracker.outcomes[ST_FULL]);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/efr_pkg.sv
rtl/efr_in_if.sv
rtl/efr_out_if.sv
rtl/efr_in_stage.sv
rtl/efr_decoder.sv
rtl/efr_out_stage.sv
rtl/escaped_frame_receiver_core.sv
rtl/efr_checker.sv
verif/escaped_frame_receiver_core_test.sv
